>>> rtl/yuyv_to_rgb888_pair_assert.svh
// Assertion macros for the YUYV to RGB888 converter.
// Depends on nothing; included by the top level only.
`ifndef YUYV_TO_RGB888_PAIR_ASSERT_SVH
`define YUYV_TO_RGB888_PAIR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define Y2R_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yuyv_to_rgb888_pair: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define Y2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yuyv_to_rgb888_pair: next-cycle check failed");

`endif

>>> rtl/y2r_pkg.sv
// Shared constants and types for the YUYV to RGB888 converter.
// No dependencies; imported by the chroma unit, the pixel lanes and the top level.
package y2r_pkg;

   localparam int BYTE_W = 8;
   localparam int PROD_W = 18;   // signed width of every constant product
   localparam int LUMA_W = 10;   // scaled luma, -19..278
   localparam int TERM_W = 10;   // chroma terms, -258..255
   localparam int SUM_W  = 11;   // luma plus or minus a term

   localparam logic signed [PROD_W-1:0] LUMA_GAIN    = 18'sd298;
   localparam logic signed [PROD_W-1:0] LUMA_ROUND   = 18'sd128;
   localparam logic signed [PROD_W-1:0] RED_FROM_V   = 18'sd409;
   localparam logic signed [PROD_W-1:0] GREEN_FROM_U = 18'sd100;
   localparam logic signed [PROD_W-1:0] GREEN_FROM_V = 18'sd208;
   localparam logic signed [PROD_W-1:0] BLUE_FROM_U  = 18'sd516;
   localparam logic signed [8:0]        LUMA_OFFSET   = 9'sd16;
   localparam logic signed [8:0]        CHROMA_OFFSET = 9'sd128;
   localparam logic signed [SUM_W-1:0]  CHAN_MAX      = 11'sd255;

   typedef struct packed {
      logic signed [TERM_W-1:0] red;
      logic signed [TERM_W-1:0] green;
      logic signed [TERM_W-1:0] blue;
   } chroma_terms_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_type;

endpackage

>>> rtl/y2r_chroma.sv
// Shared chroma unit: forms the three floor-shifted chroma terms from U and V.
// Depends on y2r_pkg; one instance feeds both pixel lanes.
module y2r_chroma (
   input  logic                          clock,
   input  logic                          load,
   input  logic [y2r_pkg::BYTE_W-1:0]    chroma_blue,
   input  logic [y2r_pkg::BYTE_W-1:0]    chroma_red,
   output y2r_pkg::chroma_terms_type     terms
);
   import y2r_pkg::*;

   logic signed [8:0]        u_c;
   logic signed [8:0]        v_c;
   logic signed [PROD_W-1:0] red_prod;
   logic signed [PROD_W-1:0] green_prod;
   logic signed [PROD_W-1:0] blue_prod;
   chroma_terms_type         terms_in;
   chroma_terms_type         terms_ff;

   always_comb begin
      u_c        = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
      v_c        = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
      red_prod   = PROD_W'(v_c) * RED_FROM_V;
      green_prod = PROD_W'(u_c) * GREEN_FROM_U + PROD_W'(v_c) * GREEN_FROM_V;
      blue_prod  = PROD_W'(u_c) * BLUE_FROM_U;
      // drop the low 8 bits: floor toward minus infinity
      terms_in.red   = red_prod[PROD_W-1:8];
      terms_in.green = green_prod[PROD_W-1:8];
      terms_in.blue  = blue_prod[PROD_W-1:8];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

>>> rtl/y2r_lane.sv
// One pixel lane: scales its luma, then applies the shared chroma terms and clamps.
// Depends on y2r_pkg; the top level runs two lanes side by side.
module y2r_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic [y2r_pkg::BYTE_W-1:0]    luma,
   input  y2r_pkg::chroma_terms_type     terms,
   output y2r_pkg::pixel_type            pixel
);
   import y2r_pkg::*;

   logic signed [8:0]        y_c;
   logic signed [PROD_W-1:0] luma_prod;
   logic signed [LUMA_W-1:0] luma_in;
   logic signed [LUMA_W-1:0] luma_ff;
   logic signed [SUM_W-1:0]  red_sum;
   logic signed [SUM_W-1:0]  green_sum;
   logic signed [SUM_W-1:0]  blue_sum;

   function automatic logic [BYTE_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] x);
      logic [BYTE_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > CHAN_MAX) begin
         r = '1;
      end else begin
         r = x[BYTE_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      y_c       = $signed({1'b0, luma}) - LUMA_OFFSET;
      luma_prod = PROD_W'(y_c) * LUMA_GAIN + LUMA_ROUND;
      luma_in   = luma_prod[PROD_W-1:8];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff <= luma_in;
      end
   end

   always_comb begin
      red_sum     = SUM_W'(luma_ff) + SUM_W'(terms.red);
      green_sum   = SUM_W'(luma_ff) - SUM_W'(terms.green);
      blue_sum    = SUM_W'(luma_ff) + SUM_W'(terms.blue);
      pixel.red   = clamp_chan(red_sum);
      pixel.green = clamp_chan(green_sum);
      pixel.blue  = clamp_chan(blue_sum);
   end

endmodule

>>> rtl/yuyv_to_rgb888_pair.sv
// YUYV macropixel to two RGB888 pixels, BT.601 integer form.
// Throughput: one macropixel per cycle while rsp_tready stays high, set by
// the two-register pipeline (constant products registered, then add, clamp
// and output register); stage 1 holds a transaction while the output stalls.
// Reset clears the stage valid flags only; payload registers are not reset.
// Depends on y2r_pkg, y2r_chroma, y2r_lane and yuyv_to_rgb888_pair_assert.svh.
`include "yuyv_to_rgb888_pair_assert.svh"

module yuyv_to_rgb888_pair (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
   // [31:24] red_second, [39:32] green_second, [47:40] blue_second
   output logic [47:0] rsp_tdata
);
   import y2r_pkg::*;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [47:0]      rsp_data_ff;
   logic [47:0]      rsp_data_in;
   logic             req_take;
   logic             s1_advance;
   chroma_terms_type terms;
   pixel_type        pix_first;
   pixel_type        pix_second;

   // Stage 1 drains into the output register when that register is empty or
   // its transaction is taken this cycle; stage 1 refills in the same cycle.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   // Shared chroma terms: one unit serves both lanes.
   y2r_chroma u_chroma (
      .clock       (clock),
      .load        (req_take),
      .chroma_blue (req_tdata[15:8]),
      .chroma_red  (req_tdata[31:24]),
      .terms       (terms)
   );

   // Two pixel lanes, one per luma byte.
   y2r_lane u_lane_first (
      .clock (clock),
      .load  (req_take),
      .luma  (req_tdata[7:0]),
      .terms (terms),
      .pixel (pix_first)
   );

   y2r_lane u_lane_second (
      .clock (clock),
      .load  (req_take),
      .luma  (req_tdata[23:16]),
      .terms (terms),
      .pixel (pix_second)
   );

   // Merge the two lanes into one result word.
   always_comb begin
      rsp_data_in = {pix_second.blue, pix_second.green, pix_second.red,
                     pix_first.blue,  pix_first.green,  pix_first.red};
   end

   // Valid flags: stage 1 holds while it cannot drain, the output holds until taken.
   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register: load only when stage 1 hands over a transaction.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted transaction always lands in stage 1.
   `Y2R_ASSERT_NEXT(a_take_fills_s1, clock, reset, req_take, s1_valid_ff)
   // A stalled output keeps stage 1 occupied: no transaction is lost.
   `Y2R_ASSERT_NEXT(a_stall_keeps_s1, clock, reset,
                    s1_valid_ff && rsp_valid_ff && !rsp_tready, s1_valid_ff && rsp_valid_ff)
   // Backpressure only when both stages are full and the output is stalled.
   `Y2R_ASSERT_SAME(a_ready_low_full, clock, reset,
                    !req_tready, s1_valid_ff && rsp_valid_ff && !rsp_tready)

endmodule

>>> verif/yuyv_to_rgb888_pair_tb.sv
// Testbench for yuyv_to_rgb888_pair: YUYV macropixels in, RGB888 pixel pairs out.
// Needs only the RTL of yuyv_to_rgb888_pair; predicts every pair in its own
// scoreboard class and checks each field of every rsp transaction.

module yuyv_to_rgb888_pair_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES   = 10;    // pipeline is two deep
   localparam int PHASE_ITEMS   = 540;
   localparam int FILL_ITEMS    = 40;

   // BT.601 integer coefficients
   localparam int Y_OFFSET  = 16;
   localparam int C_OFFSET  = 128;
   localparam int Y_GAIN    = 298;
   localparam int Y_ROUND   = 128;
   localparam int CR_TO_R   = 409;
   localparam int CB_TO_G   = 100;
   localparam int CR_TO_G   = 208;
   localparam int CB_TO_B   = 516;
   localparam int BYTE_MAX  = 255;

   // Predicts converted pixel pairs in arrival order and checks them against
   // the block's rsp transactions.
   class rgb_pair_scoreboard;
      logic [47:0] expected_pairs[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      static function logic [7:0] saturate(int x);
         if (x < 0) return 8'd0;
         if (x > BYTE_MAX) return 8'(BYTE_MAX);
         return 8'(x);
      endfunction

      // Signed >>> on int is a floor shift, so negative terms round down.
      static function logic [47:0] convert_pair(logic [31:0] yuyv);
         int cb, cr, red_term, green_term, blue_term, lum;
         logic [7:0] lumas[2];
         logic [47:0] pair;
         cb = yuyv[15:8];
         cr = yuyv[31:24];
         cb -= C_OFFSET;
         cr -= C_OFFSET;
         lumas[0] = yuyv[7:0];
         lumas[1] = yuyv[23:16];
         red_term   = (CR_TO_R * cr) >>> 8;
         green_term = (CB_TO_G * cb + CR_TO_G * cr) >>> 8;
         blue_term  = (CB_TO_B * cb) >>> 8;
         for (int p = 0; p < 2; p++) begin
            lum = (Y_GAIN * (int'(lumas[p]) - Y_OFFSET) + Y_ROUND) >>> 8;
            pair[p*24 +: 8]      = saturate(lum + red_term);
            pair[p*24 + 8 +: 8]  = saturate(lum - green_term);
            pair[p*24 + 16 +: 8] = saturate(lum + blue_term);
         end
         return pair;
      endfunction

      function void note_macropixel(logic [31:0] yuyv);
         expected_pairs.push_back(convert_pair(yuyv));
      endfunction

      function void check_pixels(logic [47:0] pixels);
         string names[6] = '{"red_first", "green_first", "blue_first",
                             "red_second", "green_second", "blue_second"};
         logic [47:0] want;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected pixel pair, expected none, got %h", $time, pixels);
            errors++;
            return;
         end
         want = expected_pairs.pop_front();
         for (int f = 0; f < 6; f++) begin
            if (pixels[f*8 +: 8] !== want[f*8 +: 8]) begin
               $display("%0t: %s expected %0d, got %0d", $time, names[f],
                        want[f*8 +: 8], pixels[f*8 +: 8]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   rgb_pair_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;     // bump to start one long receiver hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   yuyv_to_rgb888_pair u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Receiver: random back-pressure, or a long hold-off when the main
   // process bumps hold_token. The hold is counted here, in its own process.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: values read at the edge are the pre-edge ones, since every
   // driver here and every register in the block updates by nonblocking
   // assignment. Note accepted macropixels, check accepted pixel pairs,
   // and watch for a stalled run.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_macropixel(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_pixels(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d pairs pending",
                     quiet_cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one macropixel; return at the edge where the transaction is accepted.
   // At most one nonblocking write to req_tvalid per edge.
   task automatic send_macropixel(input logic [31:0] yuyv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= yuyv;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted pair has come back.
   task automatic drain_pairs();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Half of the bytes land on the interesting points: luma black and white
   // levels, chroma around zero, and the byte extremes.
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[14] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
                                  8'd129, 8'd234, 8'd235, 8'd236, 8'd240, 8'd254, 8'd255};
      if ($urandom_range(1) == 0) return corners[$urandom_range(13)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [31:0] random_macropixel();
      return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
   endfunction

   // Directed macropixels, packed {chroma_red, luma_second, chroma_blue, luma_first}.
   logic [31:0] directed[] = '{
      32'h00_00_00_00,   // every field at its minimum
      32'hFF_FF_FF_FF,   // every field at its maximum
      32'h80_10_80_10,   // video black, neutral chroma
      32'h80_EB_80_EB,   // video white, neutral chroma
      32'h80_FF_80_00,   // luma extremes, neutral chroma: both clamps
      32'h00_00_00_FF,   // strong negative chroma
      32'hFF_FF_FF_00,   // strong positive chroma
      32'hFF_80_00_80,   // red high, blue low
      32'h00_80_FF_80,   // blue high, red low
      32'h7F_80_7F_80,   // chroma one below neutral: negative terms floor down
      32'h81_80_81_80,   // chroma one above neutral
      32'h7F_11_80_10,   // small negative red term near black
      32'h80_10_7F_11,   // small negative blue term near black
      32'hF0_EB_10_EB,   // red saturates high, blue low
      32'h10_10_F0_10,   // blue high, red clamps low at black
      32'hAA_55_AA_55,   // alternating bit patterns
      32'h55_AA_55_AA,
      32'h80_0F_80_0F,   // luma below black: negative scaled luma
      32'h80_11_80_0F,   // luma straddles black
      32'h00_FF_FF_FF,   // green clamps high
      32'hFF_00_FF_00    // green clamps low
   };

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling.
      foreach (directed[i]) send_macropixel(directed[i]);
      drain_pairs();

      // Three random phases: sender-light / receiver-heavy idling, the
      // reverse, then none.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 54 : 0;
         recv_idle_pct <= (phase == 0) ? 54 : (phase == 1) ? 10 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_macropixel(random_macropixel());
            if (phase == 0 && n == PHASE_ITEMS / 2) begin
               // Hold the receiver off for a long stretch and keep offering
               // back to back, so the pipeline fills and stalls req_tready.
               hold_token <= hold_token + 1;
               send_idle_pct = 0;
               for (int k = 0; k < FILL_ITEMS; k++) send_macropixel(random_macropixel());
               send_idle_pct = 10;
            end
         end
         drain_pairs();
      end

      // Let any straggler surface before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/y2r_pkg.sv
rtl/y2r_chroma.sv
rtl/y2r_lane.sv
rtl/yuyv_to_rgb888_pair.sv
verif/yuyv_to_rgb888_pair_tb.sv
